@@ hw/rtl/length_prefix_deframer_macros.svh @@
// ----------------------------------------------------------------------------
// length_prefix_deframer_macros
// Assertion macros used by the deframer core (lpd_core).
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lpd assertion failed");
`define LPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lpd assertion failed");
`else
`define LPD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/lpd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpd_pkg
// Types, constants and header decode helpers for the deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpd_pkg;

	localparam int ByteW  = 8;
	localparam int LenW   = 31;
	localparam int StoreW = 24;
	localparam int CntW   = 3;

	localparam logic [CntW-1:0] HdrFirst   = 3'd0;
	localparam logic [CntW-1:0] HdrLast    = 3'd3;
	localparam logic [CntW-1:0] HdrPayload = 3'd4;

	localparam logic [LenW-1:0] LenOne = 31'd1;

	localparam logic [ByteW-1:0] BinFlag = 8'h80;
	localparam logic [ByteW-1:0] ChZero  = 8'h30;
	localparam logic [ByteW-1:0] ChNine  = 8'h39;
	localparam logic [ByteW-1:0] ChUpA   = 8'h41;
	localparam logic [ByteW-1:0] ChUpF   = 8'h46;
	localparam logic [ByteW-1:0] ChLoA   = 8'h61;
	localparam logic [ByteW-1:0] ChLoF   = 8'h66;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] data;
	} lpd_in_t;

	typedef struct packed {
		logic [LenW-1:0]  msg_length;
		logic             empty_res;
		logic             last;
		logic             first;
		logic [ByteW-1:0] out_byte;
	} lpd_res_t;

	// non-hex characters decode as zero
	function automatic logic [3:0] hex_digit(input logic [ByteW-1:0] c);
		logic [ByteW-1:0] d;
		begin
			d = '0;
			if (c >= ChZero && c <= ChNine) begin
				d = c - ChZero;
			end else if (c >= ChUpA && c <= ChUpF) begin
				d = c - ChUpA + 8'd10;
			end else if (c >= ChLoA && c <= ChLoF) begin
				d = c - ChLoA + 8'd10;
			end
			return d[3:0];
		end
	endfunction

	function automatic logic [LenW-1:0] decode_len(input logic [StoreW-1:0] hs,
			input logic [ByteW-1:0] b);
		logic [LenW-1:0] len;
		begin
			if ((hs[StoreW-1 -: ByteW] & BinFlag) != '0) begin
				len = {hs[StoreW-2:0], b};
			end else begin
				len = {15'd0, hex_digit(hs[23:16]), hex_digit(hs[15:8]),
					hex_digit(hs[7:0]), hex_digit(b)};
			end
			return len;
		end
	endfunction

endpackage

@@ hw/rtl/lpd_in_reg.sv @@
// ----------------------------------------------------------------------------
// lpd_in_reg
// Input register: holds one incoming byte until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpd_in_reg import lpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] data_byte
	input  logic             take,
	output lpd_in_t          beat
);

	logic             valid_s1;
	logic [ByteW-1:0] data_s1;

	assign s_axis_tready = !valid_s1 || take;
	assign beat.valid = valid_s1;
	assign beat.data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
		end
	end

endmodule

@@ hw/rtl/lpd_core.sv @@
// ----------------------------------------------------------------------------
// lpd_core
// Header collection, length decode and payload counting, one byte per cycle while res_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "length_prefix_deframer_macros.svh"

module lpd_core import lpd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  lpd_in_t  beat,
	input  logic     res_ready,
	output logic     take,
	output logic     res_valid,
	output lpd_res_t res
);

	logic [StoreW-1:0] hs_q, hs_d, hs_eff;
	logic [CntW-1:0]   cnt_q, cnt_d, cnt_eff;
	logic [LenW-1:0]   left_q, left_d;
	logic [LenW-1:0]   len_q, len_d;
	logic [LenW-1:0]   dec_len;
	logic              restart;
	logic              in_payload;

	assign take       = beat.valid && res_ready;
	assign in_payload = (cnt_q == HdrPayload) && (left_q != '0);
	assign restart    = cnt_q >= HdrPayload;
	assign cnt_eff    = restart ? HdrFirst : cnt_q;
	assign hs_eff     = restart ? '0 : hs_q;
	assign dec_len    = decode_len(hs_q, beat.data);

	always_comb begin
		hs_d      = hs_q;
		cnt_d     = cnt_q;
		left_d    = left_q;
		len_d     = len_q;
		res_valid = 1'b0;
		res       = '0;
		if (take) begin
			if (in_payload) begin
				res_valid      = 1'b1;
				res.out_byte   = beat.data;
				res.first      = left_q == len_q;
				res.last       = left_q == LenOne;
				res.msg_length = len_q;
				left_d         = left_q - LenOne;
				if (left_q == LenOne) begin
					cnt_d = HdrFirst;
					hs_d  = '0;
				end
			end else if (cnt_eff < HdrLast) begin
				hs_d   = {hs_eff[StoreW-ByteW-1:0], beat.data};
				cnt_d  = cnt_eff + 3'd1;
				left_d = restart ? '0 : left_q;
			end else begin
				hs_d  = '0;
				len_d = dec_len;
				if (dec_len == '0) begin
					cnt_d         = HdrFirst;
					left_d        = '0;
					res_valid     = 1'b1;
					res.first     = 1'b1;
					res.last      = 1'b1;
					res.empty_res = 1'b1;
				end else begin
					cnt_d  = HdrPayload;
					left_d = dec_len;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q   <= '0;
			cnt_q  <= HdrFirst;
			left_q <= '0;
			len_q  <= '0;
		end else begin
			hs_q   <= hs_d;
			cnt_q  <= cnt_d;
			left_q <= left_d;
			len_q  <= len_d;
		end
	end

	`LPD_ASSERT_IMP(a_empty_shape, clk, arst_n, res_valid && res.empty_res, res.first && res.last && res.msg_length == '0 && res.out_byte == '0)
	`LPD_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= HdrPayload)
	`LPD_ASSERT_IMP(a_left_bound, clk, arst_n, cnt_q == HdrPayload, left_q <= len_q)
	`LPD_ASSERT_NXT(a_last_ends, clk, arst_n, take && in_payload && left_q == LenOne, cnt_q == HdrFirst && hs_q == '0)

endmodule

@@ hw/rtl/lpd_out_reg.sv @@
// ----------------------------------------------------------------------------
// lpd_out_reg
// Output register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpd_out_reg import lpd_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_valid,
	input  lpd_res_t       res,
	output logic           res_ready,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [39:0]    m_axis_tdata,   // [7:0] out_byte, [38:8] msg_length, [39] zero
	output logic           m_axis_tlast,
	output logic [1:0]     m_axis_tuser    // [0] first, [1] empty_res
);

	logic     out_valid_q;
	lpd_res_t out_q;

	assign res_ready     = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.msg_length, out_q.out_byte};
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tuser  = {out_q.empty_res, out_q.first};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

endmodule

@@ hw/rtl/length_prefix_deframer.sv @@
// ----------------------------------------------------------------------------
// length_prefix_deframer
// Splits a byte stream into length-prefixed messages and tags payload beats.
//
//  channel  dir  width  contents
//  s_axis   in   8      tdata: data_byte
//  m_axis   out  40+1+2 tdata: out_byte, msg_length; tlast: last;
//                       tuser: first, empty_res
//
//  One input beat per cycle sustained while m_axis accepts; header beats
//  give no output beat, except a zero length, which gives one empty beat.
//  Data path: input register, then header/counter logic into the
//  output register.
//  Reset needs no clearing pass; the block accepts beats right after reset.
//  A stall on m_axis holds the core and backs up into s_axis_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefix_deframer import lpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] data_byte
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [7:0] out_byte, [38:8] msg_length, [39] zero
	output logic             m_axis_tlast,
	output logic [1:0]       m_axis_tuser    // [0] first, [1] empty_res
);

	lpd_in_t  beat;
	lpd_res_t res;
	logic     take;
	logic     res_valid;
	logic     res_ready;

	lpd_in_reg u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.take          (take),
		.beat          (beat)
	);

	lpd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.res_ready (res_ready),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	lpd_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_valid     (res_valid),
		.res           (res),
		.res_ready     (res_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
